>>> rtl/bounded_signature_store_unit_defines.svh
// Assertion macros for the bounded signature store checker.
// Used by bss_checker.sv only; needs a clk and rst_n in scope.
`ifndef BOUNDED_SIGNATURE_STORE_UNIT_DEFINES_SVH
`define BOUNDED_SIGNATURE_STORE_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bss_pkg.sv
// Shared types and constants for the bounded signature store.
// No dependencies; used by bss_ram, bss_ctrl and the top level.
`default_nettype none

package bss_pkg;

  localparam int KEY_W = 160;
  localparam int OCC_W = 9;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } bss_state_t;

  typedef struct packed {
    logic             found;
    logic             evicted;
    logic [OCC_W-1:0] occupancy;
  } bss_res_t;

endpackage

`default_nettype wire

>>> rtl/bss_ram.sv
// Signature ring storage: one write port, one registered read port.
// Depends on bss_pkg for the key width.
`default_nettype none

module bss_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire                       clk,
  input  wire                       wr_en,
  input  wire  [AW-1:0]             wr_addr,
  input  wire  [bss_pkg::KEY_W-1:0] wr_data,
  input  wire                       rd_en,
  input  wire  [AW-1:0]             rd_addr,
  output logic [bss_pkg::KEY_W-1:0] rd_data
);

  logic [bss_pkg::KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/bss_ctrl.sv
// Request sequencer: scans held slots oldest first, then appends on insert.
// Depends on bss_pkg; drives the ports of bss_ram.
`default_nettype none

module bss_ctrl #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int CW    = 9
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       req_valid,
  output logic                      req_ready,
  input  wire  [bss_pkg::KEY_W-1:0] req_key,
  input  wire                       req_type,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  wire  [bss_pkg::KEY_W-1:0] rd_data,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [bss_pkg::KEY_W-1:0] wr_data,
  output logic                      res_valid,
  input  wire                       res_ready,
  output bss_pkg::bss_res_t         res
);

  bss_pkg::bss_state_t       state_r, state_nxt;
  logic [AW-1:0]             oldest_r, oldest_nxt;
  logic [AW-1:0]             next_r, next_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [AW-1:0]             rd_slot_r, rd_slot_nxt;
  logic [CW-1:0]             issued_r, issued_nxt;
  logic                      pend_r, pend_nxt;
  logic                      hit_r, hit_nxt;
  logic [bss_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                      ins_r, ins_nxt;
  bss_pkg::bss_res_t         res_r, res_nxt;
  logic                      hit;
  logic [CW-1:0]             count_inc;

  function automatic logic [AW-1:0] adv(input logic [AW-1:0] slot);
    logic [AW-1:0] n;
    n = slot + AW'(1);
    return (slot == AW'(DEPTH - 1)) ? '0 : n;
  endfunction

  assign hit       = hit_r | (pend_r & (rd_data == key_r));
  assign count_inc = count_r + CW'(1);
  assign rd_addr   = rd_slot_r;
  assign wr_addr   = next_r;
  assign wr_data   = key_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bss_pkg::ST_IDLE;
      oldest_r <= '0;
      next_r   <= '0;
      count_r  <= '0;
      issued_r <= '0;
      pend_r   <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      oldest_r <= oldest_nxt;
      next_r   <= next_nxt;
      count_r  <= count_nxt;
      issued_r <= issued_nxt;
      pend_r   <= pend_nxt;
      hit_r    <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_r <= rd_slot_nxt;
    key_r     <= key_nxt;
    ins_r     <= ins_nxt;
    res_r     <= res_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    oldest_nxt  = oldest_r;
    next_nxt    = next_r;
    count_nxt   = count_r;
    rd_slot_nxt = rd_slot_r;
    issued_nxt  = issued_r;
    pend_nxt    = 1'b0;
    hit_nxt     = hit_r;
    key_nxt     = key_r;
    ins_nxt     = ins_r;
    res_nxt     = res_r;
    req_ready   = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    res_valid   = 1'b0;
    case (state_r)
      bss_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          key_nxt     = req_key;
          ins_nxt     = (req_type == bss_pkg::REQ_INSERT);
          rd_slot_nxt = oldest_r;
          issued_nxt  = '0;
          hit_nxt     = 1'b0;
          state_nxt   = bss_pkg::ST_SCAN;
        end
      end
      bss_pkg::ST_SCAN: begin
        // the pending compare folds into hit this cycle, so leave as soon as
        // nothing more is issued
        hit_nxt = hit;
        if (!hit && (issued_r != count_r)) begin
          rd_en       = 1'b1;
          pend_nxt    = 1'b1;
          issued_nxt  = issued_r + CW'(1);
          rd_slot_nxt = adv(rd_slot_r);
        end else begin
          state_nxt = bss_pkg::ST_UPDATE;
        end
      end
      bss_pkg::ST_UPDATE: begin
        res_nxt.found     = hit_r;
        res_nxt.evicted   = 1'b0;
        res_nxt.occupancy = bss_pkg::OCC_W'(count_r);
        if (ins_r) begin
          wr_en    = 1'b1;
          next_nxt = adv(next_r);
          if (count_r == CW'(DEPTH)) begin
            // full: drop the oldest, count stays
            oldest_nxt      = adv(oldest_r);
            res_nxt.evicted = 1'b1;
          end else begin
            count_nxt         = count_inc;
            res_nxt.occupancy = bss_pkg::OCC_W'(count_inc);
          end
        end
        state_nxt = bss_pkg::ST_DONE;
      end
      bss_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = bss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bss_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/bounded_signature_store_unit.sv
// Channel | Dir | Handshake        | Payload
// in_     | in  | tvalid / tready  | tuser: req_type; tdata: key_upper, key_middle, key_lower
// out_    | out | tvalid / tready  | tdata: found, evicted, occupancy
//
// From acceptance to out_tvalid, the single read port of the signature ring is walked
// one slot a cycle over the held slots, stopping early on a match. One request is
// worked on at a time; the result register lets the next request in while the previous
// result waits.
// Reset (rst_n low, synchronous) empties the ring; no clearing pass is needed.
// Top level: instantiates bss_ctrl and bss_ram, holds the result register.
`default_nettype none

module bounded_signature_store_unit #(
  parameter int DEPTH = 256
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [159:0] in_tdata,   // [63:0] key_upper, [127:64] key_middle, [159:128] key_lower
  input  wire  [0:0]   in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata    // [0] found, [1] evicted, [10:2] occupancy, [15:11] zero
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [bss_pkg::KEY_W-1:0] rd_data;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [bss_pkg::KEY_W-1:0] wr_data;
  logic                      res_valid;
  logic                      res_ready;
  bss_pkg::bss_res_t         res;
  logic                      out_valid_r;
  bss_pkg::bss_res_t         out_res_r;

  bss_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req_key   (in_tdata),
    .req_type  (in_tuser[0]),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  bss_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r.occupancy, out_res_r.evicted, out_res_r.found};

endmodule

`default_nettype wire

>>> rtl/bss_checker.sv
// Port-level checks for bounded_signature_store_unit, attached by bind.
// Depends on bounded_signature_store_unit_defines.svh for the assertion macros.
`default_nettype none
`include "bounded_signature_store_unit_defines.svh"

module bss_checker #(
  parameter int DEPTH = 256
) (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire [15:0] out_tdata,
  input wire        out_tvalid,
  input wire        out_tready
);

  // a stalled result holds
  `BSS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // one request at a time: the store is busy the cycle after it takes one
  `BSS_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "request taken while busy")

  // an eviction only happens with the ring full
  `BSS_ASSERT_NOW(a_evict_full, out_tvalid && out_tdata[1], out_tdata[10:2] == 9'(DEPTH), "eviction below capacity")

  // occupancy never goes past capacity
  `BSS_ASSERT_NOW(a_occ_bound, out_tvalid && (DEPTH < 512), out_tdata[10:2] <= DEPTH, "occupancy above capacity")

endmodule

bind bounded_signature_store_unit bss_checker #(.DEPTH(DEPTH)) u_bss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire
